>>> sv/rrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrl_pkg
// Shared types, constants and trig table for the ray line-hit locator.
// ----------------------------------------------------------------------------
package rrl_pkg;

    localparam int POLY_TERMS = 4;
    localparam int STEP_BITS  = 10;
    localparam int TERM_BITS  = $clog2(POLY_TERMS + 1);
    localparam int COEF_REGS  = 4;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    localparam logic [STEP_BITS-1:0] STEP_MAX = {STEP_BITS{1'b1}};
    localparam logic [5:0]  GAP_CEIL   = 6'd63;
    localparam logic [8:0]  FULL_TURN  = 9'd360;
    localparam logic [8:0]  QUARTER    = 9'd90;
    localparam logic [8:0]  THREE_QTR  = 9'd270;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_COEF_ZERO     = 3'd0,
        REG_COEF_ONE      = 3'd1,
        REG_COEF_TWO      = 3'd2,
        REG_COEF_THREE    = 3'd3,
        REG_NEAR_RADIUS   = 3'd4,
        REG_SCAN_LIMIT    = 3'd5,
        REG_NEAR_DISTANCE = 3'd6,
        REG_GAP_LIMIT     = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [COEF_REGS-1:0][47:0] coef;
        logic [9:0]  near_radius;
        logic [9:0]  scan_limit;
        logic [14:0] near_distance;
        logic [5:0]  gap_limit;
    } cfg_t;

    // one hit handed from front to back
    typedef struct packed {
        logic [STEP_BITS-1:0] step;
        logic [8:0]           angle;
        logic                 near;
    } hit_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_ROUND,
        ST_PX,
        ST_PY,
        ST_DONE
    } back_state_t;

    function automatic logic [14:0] quarter_sine(input logic [6:0] a);
        logic [14:0] v;
        unique case (a)
            7'd0: v = 15'd0;      7'd1: v = 15'd286;    7'd2: v = 15'd572;
            7'd3: v = 15'd857;    7'd4: v = 15'd1143;   7'd5: v = 15'd1428;
            7'd6: v = 15'd1713;   7'd7: v = 15'd1997;   7'd8: v = 15'd2280;
            7'd9: v = 15'd2563;   7'd10: v = 15'd2845;  7'd11: v = 15'd3126;
            7'd12: v = 15'd3406;  7'd13: v = 15'd3686;  7'd14: v = 15'd3964;
            7'd15: v = 15'd4240;  7'd16: v = 15'd4516;  7'd17: v = 15'd4790;
            7'd18: v = 15'd5063;  7'd19: v = 15'd5334;  7'd20: v = 15'd5604;
            7'd21: v = 15'd5872;  7'd22: v = 15'd6138;  7'd23: v = 15'd6402;
            7'd24: v = 15'd6664;  7'd25: v = 15'd6924;  7'd26: v = 15'd7182;
            7'd27: v = 15'd7438;  7'd28: v = 15'd7692;  7'd29: v = 15'd7943;
            7'd30: v = 15'd8192;  7'd31: v = 15'd8438;  7'd32: v = 15'd8682;
            7'd33: v = 15'd8923;  7'd34: v = 15'd9162;  7'd35: v = 15'd9397;
            7'd36: v = 15'd9630;  7'd37: v = 15'd9860;  7'd38: v = 15'd10087;
            7'd39: v = 15'd10311; 7'd40: v = 15'd10531; 7'd41: v = 15'd10749;
            7'd42: v = 15'd10963; 7'd43: v = 15'd11174; 7'd44: v = 15'd11381;
            7'd45: v = 15'd11585; 7'd46: v = 15'd11786; 7'd47: v = 15'd11982;
            7'd48: v = 15'd12176; 7'd49: v = 15'd12365; 7'd50: v = 15'd12551;
            7'd51: v = 15'd12733; 7'd52: v = 15'd12911; 7'd53: v = 15'd13085;
            7'd54: v = 15'd13255; 7'd55: v = 15'd13421; 7'd56: v = 15'd13583;
            7'd57: v = 15'd13741; 7'd58: v = 15'd13894; 7'd59: v = 15'd14044;
            7'd60: v = 15'd14189; 7'd61: v = 15'd14330; 7'd62: v = 15'd14466;
            7'd63: v = 15'd14598; 7'd64: v = 15'd14726; 7'd65: v = 15'd14849;
            7'd66: v = 15'd14968; 7'd67: v = 15'd15082; 7'd68: v = 15'd15191;
            7'd69: v = 15'd15296; 7'd70: v = 15'd15396; 7'd71: v = 15'd15491;
            7'd72: v = 15'd15582; 7'd73: v = 15'd15668; 7'd74: v = 15'd15749;
            7'd75: v = 15'd15826; 7'd76: v = 15'd15897; 7'd77: v = 15'd15964;
            7'd78: v = 15'd16026; 7'd79: v = 15'd16083; 7'd80: v = 15'd16135;
            7'd81: v = 15'd16182; 7'd82: v = 15'd16225; 7'd83: v = 15'd16262;
            7'd84: v = 15'd16294; 7'd85: v = 15'd16322; 7'd86: v = 15'd16344;
            7'd87: v = 15'd16362; 7'd88: v = 15'd16374; 7'd89: v = 15'd16382;
            7'd90: v = 15'd16384;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // signed Q14 sine of a whole-degree angle 0..359
    function automatic logic signed [15:0] sine_deg(input logic [8:0] a);
        logic [8:0]  r;
        logic [14:0] m;
        logic        neg;
        neg = 1'b0;
        if (a <= QUARTER)
            r = a;
        else if (a <= 9'd180)
            r = 9'd180 - a;
        else if (a <= THREE_QTR)
        begin
            r   = a - 9'd180;
            neg = 1'b1;
        end
        else
        begin
            r   = FULL_TURN - a;
            neg = 1'b1;
        end
        m = quarter_sine(r[6:0]);
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

endpackage

>>> sv/rrl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrl interfaces
// Sample, hit and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrl_in_if;
    logic       valid;
    logic       ready;
    logic       ray_start;
    logic [8:0] ray_angle;
    logic       pixel_white;
    modport source (output valid, ray_start, ray_angle, pixel_white, input ready);
    modport sink   (input valid, ray_start, ray_angle, pixel_white, output ready);
endinterface

interface rrl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [14:0]        hit_distance;
    logic [8:0]         hit_angle;
    modport source (output valid, point_x, point_y, hit_distance, hit_angle, input ready);
    modport sink   (input valid, point_x, point_y, hit_distance, hit_angle, output ready);
endinterface

interface rrl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/rrl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrl_front
// Per-sample detector: step count, arming, gap count; pushes hit jobs.
// ----------------------------------------------------------------------------
module rrl_front (
    input  logic             clk,
    input  logic             rst_n,
    rrl_in_if.sink           in_ch,
    input  rrl_pkg::cfg_t    cfg,
    output logic             push,
    output rrl_pkg::hit_job_t job,
    input  logic             q_full
);
    import rrl_pkg::*;

    // common width for step versus 10-bit register compares
    localparam int CMP_BITS = (STEP_BITS > 10) ? STEP_BITS : 10;

    logic                 armed_reg, armed_next;
    logic [5:0]           gap_reg, gap_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 past_end_reg, past_end_next;

    logic                 take;
    logic                 arm_e, pe_e, active;
    logic [5:0]           gap_e;
    logic [STEP_BITS-1:0] step_e;
    logic [8:0]           angle;

    assign in_ch.ready = !q_full;
    assign take        = in_ch.valid && in_ch.ready;

    // effective state after a ray start
    always_comb
    begin
        arm_e  = in_ch.ray_start ? 1'b1 : armed_reg;
        gap_e  = in_ch.ray_start ? 6'd0 : gap_reg;
        step_e = in_ch.ray_start ? '0 : step_reg;
        pe_e   = in_ch.ray_start ? 1'b0 : past_end_reg;
        angle  = (in_ch.ray_angle >= FULL_TURN) ? in_ch.ray_angle - FULL_TURN
                                                 : in_ch.ray_angle;
        active = !pe_e && (CMP_BITS'(cfg.scan_limit) >= CMP_BITS'(step_e));
    end

    // detector update
    always_comb
    begin
        armed_next    = arm_e;
        gap_next      = gap_e;
        step_next     = step_e;
        past_end_next = pe_e;
        push          = 1'b0;
        if (active)
        begin
            if (in_ch.pixel_white)
            begin
                if (arm_e)
                begin
                    push       = take;
                    armed_next = 1'b0;
                end
            end
            else if (gap_e > cfg.gap_limit)
            begin
                armed_next = 1'b1;
                gap_next   = 6'd0;
            end
            else if (gap_e < GAP_CEIL)
            begin
                gap_next = gap_e + 6'd1;
            end
        end
        if (!pe_e)
        begin
            if (step_e == STEP_MAX)
                past_end_next = 1'b1;
            else
                step_next = step_e + 1'b1;
        end
    end

    always_comb
    begin
        job.step  = step_e;
        job.angle = angle;
        job.near  = CMP_BITS'(step_e) < CMP_BITS'(cfg.near_radius);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg    <= 1'b1;
            gap_reg      <= 6'd0;
            step_reg     <= '0;
            past_end_reg <= 1'b0;
        end
        else if (take)
        begin
            armed_reg    <= armed_next;
            gap_reg      <= gap_next;
            step_reg     <= step_next;
            past_end_reg <= past_end_next;
        end
    end

endmodule

>>> sv/rrl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrl_queue
// Short FIFO of hit jobs between front and back.
// ----------------------------------------------------------------------------
module rrl_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rrl_pkg::hit_job_t push_job,
    output logic              full,
    input  logic              pop,
    output rrl_pkg::hit_job_t pop_job,
    output logic              not_empty
);
    import rrl_pkg::*;

    hit_job_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_reg, rd_reg;
    logic [Q_PTR_BITS:0]   count_reg;

    assign full      = (count_reg == Q_PTR_BITS'(0) + (Q_PTR_BITS+1)'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_job   = mem_reg[rd_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            count_reg <= count_reg + (Q_PTR_BITS+1)'(push) - (Q_PTR_BITS+1)'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("push into full hit queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
        else $error("pop from empty hit queue");
    assert property (@(posedge clk) disable iff (!rst_n)
                     count_reg <= (Q_PTR_BITS+1)'(Q_DEPTH))
        else $error("hit queue count overflow");

endmodule

>>> sv/rrl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrl_back
// Hit evaluator: Horner polynomial with saturation, rounding, x/y scaling.
// ----------------------------------------------------------------------------
module rrl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rrl_pkg::cfg_t     cfg,
    input  logic              job_avail,
    input  rrl_pkg::hit_job_t job,
    output logic              pop,
    rrl_out_if.source         out_ch
);
    import rrl_pkg::*;

    localparam logic signed [64:0] ACC_BOUND = 65'sd1 <<< 62;

    back_state_t state_reg, state_next;

    logic [STEP_BITS-1:0]  p_reg;
    logic [8:0]            angle_reg;
    logic                  near_reg;
    logic [TERM_BITS-1:0]  term_reg;
    logic signed [63:0]    acc_reg;
    logic [62+STEP_BITS:0] prod_reg;
    logic                  neg_reg;
    logic [14:0]           d_reg;
    logic signed [15:0]    x_reg;
    logic signed [15:0]    y_reg;
    logic                  out_valid_reg;

    logic                  load_out;
    logic [62:0]           acc_mag;
    logic [62:0]           prod_sat;
    logic signed [64:0]    sum;
    logic signed [47:0]    coef_sel;
    logic [8:0]            cos_angle;
    logic signed [15:0]    sin_v;
    logic [14:0]           sin_mag;
    logic [29:0]           scaled;
    logic signed [15:0]    scaled_s;
    logic [35:0]           rnd;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (job_avail) state_next = job.near ? ST_ROUND : ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = (term_reg == '0) ? ST_ROUND : ST_MUL;
            ST_ROUND: state_next = ST_PX;
            ST_PX:    state_next = ST_PY;
            ST_PY:    state_next = ST_DONE;
            ST_DONE:  if (!out_valid_reg || out_ch.ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: pop      = job_avail;
            ST_DONE: load_out = !out_valid_reg || out_ch.ready;
            default: ;
        endcase
    end

    // datapath helpers
    always_comb
    begin
        acc_mag  = acc_reg[63] ? 63'(-acc_reg) : acc_reg[62:0];
        prod_sat = (prod_reg > (62+STEP_BITS+1)'(ACC_BOUND)) ? 63'(ACC_BOUND)
                                                              : prod_reg[62:0];
        coef_sel = 48'sd0;
        for (int i = 0; i < COEF_REGS; i++)
            if (TERM_BITS'(i) == term_reg)
                coef_sel = $signed(cfg.coef[i]);
        sum = (neg_reg ? -$signed({2'b00, prod_sat}) : $signed({2'b00, prod_sat}))
              + 65'(coef_sel);
        rnd = 36'(acc_reg[62:0] + 63'(1 << 27) >> 28);
        cos_angle = (angle_reg < THREE_QTR) ? angle_reg + QUARTER : angle_reg - THREE_QTR;
        sin_v   = sine_deg(state_reg == ST_PX ? cos_angle : angle_reg);
        sin_mag = sin_v[15] ? 15'(-sin_v) : sin_v[14:0];
        scaled  = 30'((30'(d_reg) * 30'(sin_mag) + 30'd8192) >> 14);
        scaled_s = sin_v[15] ? -$signed(scaled[15:0]) : $signed(scaled[15:0]);
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                p_reg     <= job.step;
                angle_reg <= job.angle;
                near_reg  <= job.near;
                term_reg  <= TERM_BITS'(POLY_TERMS - 1);
                acc_reg   <= '0;
            end
            ST_MUL:
            begin
                prod_reg <= (62+STEP_BITS+1)'(acc_mag) * (62+STEP_BITS+1)'(p_reg);
                neg_reg  <= acc_reg[63];
            end
            ST_ADD:
            begin
                if (sum > ACC_BOUND)
                    acc_reg <= 64'(ACC_BOUND);
                else if (sum < -ACC_BOUND)
                    acc_reg <= 64'(-ACC_BOUND);
                else
                    acc_reg <= 64'(sum);
                term_reg <= term_reg - 1'b1;
            end
            ST_ROUND:
            begin
                if (near_reg)
                    d_reg <= cfg.near_distance;
                else if (acc_reg <= 64'sd0)
                    d_reg <= 15'd0;
                else if (rnd > 36'd32767)
                    d_reg <= 15'd32767;
                else
                    d_reg <= rnd[14:0];
            end
            ST_PX:   x_reg <= scaled_s;
            ST_PY:   y_reg <= scaled_s;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_ch.point_x      <= x_reg;
            out_ch.point_y      <= y_reg;
            out_ch.hit_distance <= d_reg;
            out_ch.hit_angle    <= angle_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
                     state_reg == ST_MUL |=> state_reg == ST_ADD)
        else $error("multiply not followed by add");
    assert property (@(posedge clk) disable iff (!rst_n)
                     state_reg == ST_ROUND && !near_reg |->
                     acc_reg <= 64'(ACC_BOUND) && acc_reg >= 64'(-ACC_BOUND))
        else $error("accumulator outside saturation bound");
    assert property (@(posedge clk) disable iff (!rst_n)
                     pop |=> state_reg == ST_MUL || state_reg == ST_ROUND)
        else $error("job pop without evaluation start");

endmodule

>>> sv/radial_ray_line_hit_locator.sv
`timescale 1ns / 1ps
// Throughput: one sample per cycle while the hit queue is not full; hits are
// evaluated one at a time by the back end, which reuses its Horner multiplier.
// A 4-entry hit queue absorbs bursts; sample intake stalls while it is full.
// Reset: detector armed, counts zero, registers at their defaults, no clear pass.
// ----------------------------------------------------------------------------
// radial_ray_line_hit_locator
// Top level: config registers, sample front end, hit queue, hit back end.
// ----------------------------------------------------------------------------
module radial_ray_line_hit_locator (
    input  logic      clk,
    input  logic      rst_n,
    rrl_in_if.sink    in_ch,
    rrl_out_if.source out_ch,
    rrl_cfg_if.sink   cfg_ch
);
    import rrl_pkg::*;

    cfg_t     cfg_reg;
    logic     push, q_full, pop, q_avail;
    hit_job_t push_job, pop_job;

    // configuration register file
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef          <= {48'd0, 48'd0, 48'd4294967296, 48'd0};
            cfg_reg.near_radius   <= 10'd0;
            cfg_reg.scan_limit    <= 10'd1023;
            cfg_reg.near_distance <= 15'd800;
            cfg_reg.gap_limit     <= 6'd5;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_reg_t'(cfg_ch.index))
                REG_COEF_ZERO:     cfg_reg.coef[0]       <= cfg_ch.data;
                REG_COEF_ONE:      cfg_reg.coef[1]       <= cfg_ch.data;
                REG_COEF_TWO:      cfg_reg.coef[2]       <= cfg_ch.data;
                REG_COEF_THREE:    cfg_reg.coef[3]       <= cfg_ch.data;
                REG_NEAR_RADIUS:   cfg_reg.near_radius   <= cfg_ch.data[9:0];
                REG_SCAN_LIMIT:    cfg_reg.scan_limit    <= cfg_ch.data[9:0];
                REG_NEAR_DISTANCE: cfg_reg.near_distance <= cfg_ch.data[14:0];
                REG_GAP_LIMIT:     cfg_reg.gap_limit     <= cfg_ch.data[5:0];
                default: ;
            endcase
        end
    end

    rrl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg    (cfg_reg),
        .push   (push),
        .job    (push_job),
        .q_full (q_full)
    );

    rrl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .pop_job   (pop_job),
        .not_empty (q_avail)
    );

    rrl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_avail (q_avail),
        .job       (pop_job),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule
